### hdl/wfqs_pkg.sv
package wfqs_pkg;

  // default sizes
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_FRAC_BITS   = 16;

  // fixed field widths
  localparam int ID_W   = 16;
  localparam int LEN_W  = 16;
  localparam int WT_W   = 8;
  localparam int DUR_W  = 16;
  localparam int TIME_W = 32;
  localparam int CAP_W  = 5;
  localparam int EV_W   = 2;
  localparam int OCC_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_ADV = 1'b1;

  // result event codes
  localparam logic [EV_W-1:0] EV_ACCEPT = 2'd0;
  localparam logic [EV_W-1:0] EV_DROP   = 2'd1;
  localparam logic [EV_W-1:0] EV_SERVED = 2'd2;
  localparam logic [EV_W-1:0] EV_IDLE   = 2'd3;

  // zero weight counts as weight one
  function automatic logic [WT_W-1:0] fix_weight(input logic [WT_W-1:0] w);
    fix_weight = (w == '0) ? WT_W'(1) : w;
  endfunction

endpackage

### hdl/wfqs_div.sv
module wfqs_div import wfqs_pkg::*; #(
  parameter int DW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DW-1:0]   dividend_i,
  input  logic [WT_W-1:0] divisor_i,
  output logic            done_o,
  output logic [DW-1:0]   quot_o
);

  localparam int CW = $clog2(DW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [DW-1:0]   quot_q, quot_d;
  logic [WT_W-1:0] rem_q, rem_d;
  logic [WT_W-1:0] div_q, div_d;
  logic [WT_W:0]   trial;
  logic            ge;

  // one restoring step per cycle, quotient shifts in as dividend shifts out
  assign trial = {rem_q, quot_q[DW-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[DW-2:0], ge};
      rem_d  = ge ? WT_W'(trial - {1'b0, div_q}) : WT_W'(trial);
      cnt_d  = cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### hdl/weighted_fair_queue_scheduler_core.sv
// channel   direction  handshake                   payload
// s_axis    in         s_axis_tvalid/s_axis_tready tdata, tuser=cmd
// m_axis    out        m_axis_tvalid/m_axis_tready tdata, tuser=event, tlast
// cfg       in         cfg_valid_i/cfg_ready_o     capacity
//
// one request at a time; an enqueue runs the shared bit-serial divider once for its tag,
// an advance runs it once per served chunk and after each completion searches the
// slots for the smallest tag, one slot at a time
// input is not ready until every result of the current request has been taken
// reset clears valid bits, clocks and counters; slot contents stay undefined
module weighted_fair_queue_scheduler_core import wfqs_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // packet_id, packet_length, weight, duration
  input  logic [55:0]       s_axis_tdata,
  // cmd
  input  logic [0:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // served_id, delay, now, served_total, occupancy, zero fill
  output logic [119:0]      m_axis_tdata,
  // event_res
  output logic [EV_W-1:0]   m_axis_tuser,
  output logic              m_axis_tlast,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CAP_W-1:0]  cfg_data_i
);

  localparam int IW   = $clog2(QUEUE_DEPTH);
  localparam int HW   = $clog2(QUEUE_DEPTH + 1);
  localparam int VW   = TIME_W + FRAC_BITS;
  localparam int DW   = LEN_W + FRAC_BITS;
  localparam int CMPW = (HW > CAP_W) ? HW : CAP_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ENQ_DIV  = 4'd1;
  localparam logic [3:0] S_ADV_TOP  = 4'd2;
  localparam logic [3:0] S_ADV_RD   = 4'd3;
  localparam logic [3:0] S_ADV_GO   = 4'd4;
  localparam logic [3:0] S_ADV_DIV  = 4'd5;
  localparam logic [3:0] S_SRCH_RD  = 4'd6;
  localparam logic [3:0] S_SRCH_CMP = 4'd7;
  localparam logic [3:0] S_SRCH_END = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  // input fields
  logic [ID_W-1:0]  in_id;
  logic [LEN_W-1:0] in_len;
  logic [WT_W-1:0]  in_wt;
  logic [DUR_W-1:0] in_dur;
  logic             in_cmd;
  assign in_id  = s_axis_tdata[15:0];
  assign in_len = s_axis_tdata[31:16];
  assign in_wt  = s_axis_tdata[39:32];
  assign in_dur = s_axis_tdata[55:40];
  assign in_cmd = s_axis_tuser[0];

  // control state
  logic [3:0]             state_q, state_d, ret_q, ret_d;
  logic [CAP_W-1:0]       cap_q, cap_d;
  logic [QUEUE_DEPTH-1:0] valid_q, valid_d;
  logic [HW-1:0]          held_q, held_d;
  logic [IW-1:0]          svc_q, svc_d;
  logic                   active_q, active_d;
  logic [VW-1:0]          vclk_q, vclk_d;
  logic [TIME_W-1:0]      gclk_q, gclk_d;
  logic [TIME_W-1:0]      served_q, served_d;
  logic [DUR_W-1:0]       left_q, left_d;
  logic                   cmp_q, cmp_d;
  logic                   pend_q, pend_d;
  logic                   any_q, any_d;
  logic [IW-1:0]          idx_q, idx_d, best_q, best_d;
  logic                   found_q, found_d;
  logic                   ov_q, ov_d;

  // payload registers
  logic [ID_W-1:0]   id_q, id_d;
  logic [IW-1:0]     slot_q, slot_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [WT_W-1:0]   wt_q, wt_d;
  logic [VW-1:0]     best_tag_q, best_tag_d;
  logic [EV_W-1:0]   oev_q, oev_d;
  logic [ID_W-1:0]   oid_q, oid_d;
  logic [TIME_W-1:0] odly_q, odly_d, onow_q, onow_d, otot_q, otot_d;
  logic [OCC_W-1:0]  oocc_q, oocc_d;
  logic              olast_q, olast_d;

  // slot memories
  logic [VW-1:0]     tag_m   [QUEUE_DEPTH];
  logic [LEN_W-1:0]  rem_m   [QUEUE_DEPTH];
  logic [WT_W-1:0]   wt_m    [QUEUE_DEPTH];
  logic [TIME_W-1:0] arr_m   [QUEUE_DEPTH];
  logic [ID_W-1:0]   ident_m [QUEUE_DEPTH];
  logic [VW-1:0]     rd_tag_q;
  logic [LEN_W-1:0]  rd_rem_q;
  logic [WT_W-1:0]   rd_wt_q;
  logic [TIME_W-1:0] rd_arr_q;
  logic [ID_W-1:0]   rd_ident_q;
  logic              rd_en, wr_en, wr_full;
  logic [IW-1:0]     rd_addr, wr_addr;
  logic [LEN_W-1:0]  wr_rem;
  logic [VW-1:0]     wr_tag;

  // divider
  logic          div_start, div_done;
  logic [DW-1:0] div_dividend, div_quot;
  logic [WT_W-1:0] div_divisor;

  // free slot, lowest index wins
  logic [IW-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_slot = IW'(i);
    end
  end

  logic             room;
  logic [LEN_W-1:0] chunk;
  logic             srch_last;
  logic [TIME_W-1:0] gclk_new;
  assign room = (CMPW'(held_q) < CMPW'(cap_q)) && (held_q < HW'(QUEUE_DEPTH));
  assign chunk = cmp_q ? rd_rem_q : left_q;
  assign srch_last = (idx_q == IW'(QUEUE_DEPTH - 1));
  assign gclk_new = gclk_q + TIME_W'(chunk);

  assign div_dividend = (state_q == S_IDLE) ? {in_len, {FRAC_BITS{1'b0}}}
                                            : {chunk, {FRAC_BITS{1'b0}}};
  assign div_divisor  = (state_q == S_IDLE) ? fix_weight(in_wt) : fix_weight(rd_wt_q);

  wfqs_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // sequencer
  always_comb begin
    state_d = state_q;  ret_d = ret_q;  cap_d = cap_q;
    valid_d = valid_q;  held_d = held_q;  svc_d = svc_q;  active_d = active_q;
    vclk_d = vclk_q;  gclk_d = gclk_q;  served_d = served_q;  left_d = left_q;
    cmp_d = cmp_q;  pend_d = pend_q;  any_d = any_q;
    idx_d = idx_q;  best_d = best_q;  found_d = found_q;  best_tag_d = best_tag_q;
    ov_d = ov_q;  id_d = id_q;  slot_d = slot_q;  len_d = len_q;  wt_d = wt_q;
    oev_d = oev_q;  oid_d = oid_q;  odly_d = odly_q;  onow_d = onow_q;
    otot_d = otot_q;  oocc_d = oocc_q;  olast_d = olast_q;
    div_start = 1'b0;
    rd_en = 1'b0;  rd_addr = svc_q;
    wr_en = 1'b0;  wr_full = 1'b0;  wr_addr = slot_q;
    wr_rem = len_q;  wr_tag = vclk_q + VW'(div_quot);

    if (cfg_valid_i) cap_d = cfg_data_i;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (in_cmd == CMD_ADV) begin
            left_d  = in_dur;
            any_d   = 1'b0;
            pend_d  = 1'b0;
            state_d = S_ADV_TOP;
          end else if (room) begin
            id_d      = in_id;
            len_d     = in_len;
            wt_d      = fix_weight(in_wt);
            slot_d    = free_slot;
            div_start = 1'b1;
            state_d   = S_ENQ_DIV;
          end else begin
            oev_d = EV_DROP;  oid_d = in_id;  odly_d = '0;  onow_d = gclk_q;
            otot_d = served_q;  oocc_d = OCC_W'(held_q);  olast_d = 1'b1;
            ov_d = 1'b1;  ret_d = S_IDLE;  state_d = S_OUT;
          end
        end
      end
      // admit the packet once its tag is known
      S_ENQ_DIV: begin
        if (div_done) begin
          wr_en = 1'b1;  wr_full = 1'b1;
          valid_d[slot_q] = 1'b1;
          held_d = held_q + HW'(1);
          if (!active_q) begin
            svc_d = slot_q;  active_d = 1'b1;
          end
          oev_d = EV_ACCEPT;  oid_d = id_q;  odly_d = '0;  onow_d = gclk_q;
          otot_d = served_q;  oocc_d = OCC_W'(held_q + HW'(1));  olast_d = 1'b1;
          ov_d = 1'b1;  ret_d = S_IDLE;  state_d = S_OUT;
        end
      end
      // loop head of the advance
      S_ADV_TOP: begin
        if (left_q != '0 && active_q) begin
          rd_en   = 1'b1;
          state_d = S_ADV_RD;
        end else begin
          gclk_d = gclk_q + TIME_W'(left_q);
          left_d = '0;
          if (pend_q) begin
            pend_d = 1'b0;  olast_d = 1'b1;  ov_d = 1'b1;
            ret_d = S_IDLE;  state_d = S_OUT;
          end else if (!any_q) begin
            oev_d = EV_IDLE;  oid_d = '0;  odly_d = '0;
            onow_d = gclk_q + TIME_W'(left_q);
            otot_d = served_q;  oocc_d = OCC_W'(held_q);  olast_d = 1'b1;
            ov_d = 1'b1;  ret_d = S_IDLE;  state_d = S_OUT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      // decide completion, which also settles the pending result
      S_ADV_RD: begin
        cmp_d = (rd_rem_q <= left_q);
        if (pend_q) begin
          pend_d = 1'b0;  olast_d = !(rd_rem_q <= left_q);  ov_d = 1'b1;
          ret_d = S_ADV_GO;  state_d = S_OUT;
        end else begin
          state_d = S_ADV_GO;
        end
      end
      S_ADV_GO: begin
        div_start = 1'b1;
        state_d   = S_ADV_DIV;
      end
      // apply one served chunk
      S_ADV_DIV: begin
        if (div_done) begin
          vclk_d = vclk_q + VW'(div_quot);
          gclk_d = gclk_new;
          left_d = left_q - chunk;
          if (cmp_q) begin
            valid_d[svc_q] = 1'b0;
            held_d   = held_q - HW'(1);
            served_d = served_q + TIME_W'(1);
            oev_d = EV_SERVED;  oid_d = rd_ident_q;  odly_d = gclk_new - rd_arr_q;
            onow_d = gclk_new;  otot_d = served_q + TIME_W'(1);
            oocc_d = OCC_W'(held_q - HW'(1));
            pend_d = 1'b1;  any_d = 1'b1;
            idx_d = '0;  found_d = 1'b0;  best_d = '0;
            state_d = S_SRCH_RD;
          end else begin
            wr_en = 1'b1;  wr_addr = svc_q;  wr_rem = rd_rem_q - left_q;
            state_d = S_ADV_TOP;
          end
        end
      end
      // smallest tag search, one slot at a time
      S_SRCH_RD: begin
        if (valid_q[idx_q]) begin
          rd_en = 1'b1;  rd_addr = idx_q;  state_d = S_SRCH_CMP;
        end else if (srch_last) begin
          state_d = S_SRCH_END;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_SRCH_CMP: begin
        if (!found_q || rd_tag_q < best_tag_q) begin
          found_d = 1'b1;  best_d = idx_q;  best_tag_d = rd_tag_q;
        end
        if (srch_last) begin
          state_d = S_SRCH_END;
        end else begin
          idx_d = idx_q + IW'(1);  state_d = S_SRCH_RD;
        end
      end
      S_SRCH_END: begin
        svc_d = best_q;  active_d = found_q;  state_d = S_ADV_TOP;
      end
      S_OUT: begin
        if (m_axis_tready) begin
          ov_d = 1'b0;  state_d = ret_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;  ret_q <= S_IDLE;  cap_q <= CAP_RESET;
      valid_q <= '0;  held_q <= '0;  svc_q <= '0;  active_q <= 1'b0;
      vclk_q <= '0;  gclk_q <= '0;  served_q <= '0;  left_q <= '0;
      cmp_q <= 1'b0;  pend_q <= 1'b0;  any_q <= 1'b0;
      idx_q <= '0;  best_q <= '0;  found_q <= 1'b0;  ov_q <= 1'b0;
    end else begin
      state_q <= state_d;  ret_q <= ret_d;  cap_q <= cap_d;
      valid_q <= valid_d;  held_q <= held_d;  svc_q <= svc_d;  active_q <= active_d;
      vclk_q <= vclk_d;  gclk_q <= gclk_d;  served_q <= served_d;  left_q <= left_d;
      cmp_q <= cmp_d;  pend_q <= pend_d;  any_q <= any_d;
      idx_q <= idx_d;  best_q <= best_d;  found_q <= found_d;  ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;  slot_q <= slot_d;  len_q <= len_d;  wt_q <= wt_d;
    best_tag_q <= best_tag_d;
    oev_q <= oev_d;  oid_q <= oid_d;  odly_q <= odly_d;  onow_q <= onow_d;
    otot_q <= otot_d;  oocc_q <= oocc_d;  olast_q <= olast_d;
  end

  // slot memories, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rem_m[wr_addr] <= wr_rem;
      if (wr_full) begin
        tag_m[wr_addr]   <= wr_tag;
        wt_m[wr_addr]    <= wt_q;
        arr_m[wr_addr]   <= gclk_q;
        ident_m[wr_addr] <= id_q;
      end
    end
    if (rd_en) begin
      rd_tag_q   <= tag_m[rd_addr];
      rd_rem_q   <= rem_m[rd_addr];
      rd_wt_q    <= wt_m[rd_addr];
      rd_arr_q   <= arr_m[rd_addr];
      rd_ident_q <= ident_m[rd_addr];
    end
  end

  // ports
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = oev_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {3'b000, oocc_q, otot_q, onow_q, odly_q, oid_q};

  // checks
  a_held_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    HW'($countones(valid_q)) == held_q) else $error("held count off");
  a_held_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HW'(QUEUE_DEPTH)) else $error("held count above depth");
  a_svc_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && state_q == S_IDLE) |-> valid_q[svc_q]) else $error("service slot empty");
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("input ready with result pending");
  a_active_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (active_q == (held_q != '0))) else $error("service flag off");

endmodule

### sim/wfqs_checker.sv
module wfqs_checker import wfqs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [55:0]       s_axis_tdata,
  input  logic [0:0]        s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [119:0]      m_axis_tdata,
  input  logic [EV_W-1:0]   m_axis_tuser,
  input  logic              m_axis_tlast,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_o,
  input  logic [CAP_W-1:0]  cfg_data_i,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = DEF_QUEUE_DEPTH;
  localparam int FRAC  = DEF_FRAC_BITS;

  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [ID_W-1:0]   ident;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] total;
    logic [OCC_W-1:0]  occ;
    logic              last;
  } sched_result_t;

  sched_result_t     expected_q[$];

  // scheduler shadow state
  logic [47:0]       slot_tag    [SLOTS];
  logic [LEN_W-1:0]  slot_left   [SLOTS];
  logic [WT_W-1:0]   slot_weight [SLOTS];
  logic [TIME_W-1:0] slot_arrival[SLOTS];
  logic [ID_W-1:0]   slot_ident  [SLOTS];
  logic              slot_busy   [SLOTS];
  int                serving_slot;
  logic              serving;
  logic [47:0]       vclock;
  logic [TIME_W-1:0] gclock;
  logic [TIME_W-1:0] served_cnt;
  logic [CAP_W-1:0]  cap_limit;

  function automatic int held_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (slot_busy[i]) n++;
    return n;
  endfunction

  function automatic logic [47:0] vtime_step(logic [31:0] amount, logic [WT_W-1:0] w);
    logic [47:0] wt;
    wt = (w == '0) ? 48'd1 : {40'd0, w};
    return ({16'd0, amount} << FRAC) / wt;
  endfunction

  task automatic push_result(logic [EV_W-1:0] ev, logic [ID_W-1:0] ident,
                             logic [TIME_W-1:0] dly);
    sched_result_t r;
    r.ev    = ev;
    r.ident = ident;
    r.delay = dly;
    r.now   = gclock;
    r.total = served_cnt;
    r.occ   = OCC_W'(held_count());
    r.last  = 1'b0;
    expected_q.push_back(r);
  endtask

  // smallest tag wins, lowest slot on ties
  task automatic select_next();
    logic found;
    int best;
    found = 1'b0;
    best  = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_busy[i] && (!found || slot_tag[i] < slot_tag[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    serving_slot = best;
    serving      = found;
  endtask

  task automatic schedule_request(logic cmd, logic [ID_W-1:0] ident, logic [LEN_W-1:0] len,
                                  logic [WT_W-1:0] w, logic [DUR_W-1:0] dur);
    int free_slot;
    int produced;
    int s;
    logic [31:0] left;
    logic [31:0] rem;
    free_slot = -1;
    produced  = 0;
    left      = {16'd0, dur};
    if (cmd == CMD_ENQ) begin
      for (int i = SLOTS - 1; i >= 0; i--) if (!slot_busy[i]) free_slot = i;
      if (held_count() < int'(cap_limit) && free_slot >= 0) begin
        slot_tag[free_slot]     = vclock + vtime_step({16'd0, len}, w);
        slot_left[free_slot]    = len;
        slot_weight[free_slot]  = (w == '0) ? WT_W'(1) : w;
        slot_arrival[free_slot] = gclock;
        slot_ident[free_slot]   = ident;
        slot_busy[free_slot]    = 1'b1;
        if (!serving) begin
          serving_slot = free_slot;
          serving      = 1'b1;
        end
        push_result(EV_ACCEPT, ident, '0);
      end else begin
        push_result(EV_DROP, ident, '0);
      end
      produced = 1;
    end else begin
      // non-preemptive service of whole packets, then partial progress
      while (left > 0 && serving) begin
        s   = serving_slot;
        rem = {16'd0, slot_left[s]};
        if (rem <= left) begin
          left       = left - rem;
          gclock     = gclock + rem;
          vclock     = vclock + vtime_step(rem, slot_weight[s]);
          slot_left[s] = '0;
          slot_busy[s] = 1'b0;
          served_cnt = served_cnt + 1;
          select_next();
          push_result(EV_SERVED, slot_ident[s], gclock - slot_arrival[s]);
          produced++;
        end else begin
          vclock       = vclock + vtime_step(left, slot_weight[s]);
          slot_left[s] = LEN_W'(rem - left);
          gclock       = gclock + left;
          left         = 0;
        end
      end
      gclock = gclock + left;
      if (produced == 0) push_result(EV_IDLE, '0, '0);
    end
    expected_q[$].last = 1'b1;
  endtask

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    $display("mismatch in %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
      serving_slot = 0;
      serving      = 1'b0;
      vclock       = '0;
      gclock       = '0;
      served_cnt   = '0;
      cap_limit    = CAP_RESET;
      fail_count   = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) cap_limit = cfg_data_i;
      // predict results for each accepted request
      if (s_axis_tvalid && s_axis_tready)
        schedule_request(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[31:16],
                         s_axis_tdata[39:32], s_axis_tdata[55:40]);
      // compare each accepted result with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", '0, 64'({m_axis_tuser, m_axis_tdata[15:0]}));
        end else begin
          exp_r = expected_q.pop_front();
          if (m_axis_tuser != exp_r.ev)
            report("event", 64'(exp_r.ev), 64'(m_axis_tuser));
          if (m_axis_tdata[15:0] != exp_r.ident)
            report("id", 64'(exp_r.ident), 64'(m_axis_tdata[15:0]));
          if (m_axis_tdata[47:16] != exp_r.delay)
            report("delay", 64'(exp_r.delay), 64'(m_axis_tdata[47:16]));
          if (m_axis_tdata[79:48] != exp_r.now)
            report("now", 64'(exp_r.now), 64'(m_axis_tdata[79:48]));
          if (m_axis_tdata[111:80] != exp_r.total)
            report("served total", 64'(exp_r.total), 64'(m_axis_tdata[111:80]));
          if (m_axis_tdata[116:112] != exp_r.occ)
            report("occupancy", 64'(exp_r.occ), 64'(m_axis_tdata[116:112]));
          if (m_axis_tlast != exp_r.last)
            report("last", 64'(exp_r.last), 64'(m_axis_tlast));
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

### sim/tb.sv
module tb import wfqs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [55:0]       s_axis_tdata = '0;
  logic [0:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [119:0]      m_axis_tdata;
  logic [EV_W-1:0]   m_axis_tuser;
  logic              m_axis_tlast;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CAP_W-1:0]  cfg_data_i = '0;
  int                fail_count;
  int                pending;
  logic              quiet = 1'b0;
  int                rx_stall = 0;
  int                idle_cycles = 0;

  weighted_fair_queue_scheduler_core DUT (.*);

  wfqs_checker u_checker (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sink side backpressure in bursts
  always @(posedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall      <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      rx_stall      <= $urandom_range(1, 17) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(logic cmd, logic [ID_W-1:0] ident, logic [LEN_W-1:0] len,
                              logic [WT_W-1:0] w, logic [DUR_W-1:0] dur);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {dur, w, len, ident};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // capacity changes only once the scheduler has drained its results
  task automatic set_capacity(logic [CAP_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_request();
    logic [LEN_W-1:0] len;
    logic [DUR_W-1:0] dur;
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = 16'hffff;
      2:       len = LEN_W'($urandom_range(1, 65535));
      default: len = LEN_W'($urandom_range(1, 200));
    endcase
    case ($urandom_range(0, 9))
      0:       dur = '0;
      1:       dur = 16'hffff;
      2:       dur = DUR_W'($urandom_range(0, 65535));
      default: dur = DUR_W'($urandom_range(1, 400));
    endcase
    if ($urandom_range(0, 9) < 6)
      send_request(CMD_ENQ, ID_W'($urandom_range(0, 65535)), len,
                   WT_W'($urandom_range(0, 255)), dur);
    else
      send_request(CMD_ADV, ID_W'($urandom_range(0, 65535)), len,
                   WT_W'($urandom_range(0, 255)), dur);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, zero weight and length, ties, busy arrivals
    send_request(CMD_ADV, '0, '0, '0, 16'hffff);
    send_request(CMD_ENQ, '0, 16'd1, 8'd1, '0);
    send_request(CMD_ENQ, 16'hffff, 16'hffff, 8'hff, '0);
    send_request(CMD_ENQ, 16'h1234, 16'd100, 8'd0, '0);
    send_request(CMD_ENQ, 16'h0042, 16'd0, 8'd7, '0);
    send_request(CMD_ADV, '0, '0, '0, '0);
    send_request(CMD_ADV, 16'hffff, 16'hffff, 8'hff, 16'd1);
    send_request(CMD_ENQ, 16'h00a1, 16'd50, 8'd5, '0);
    send_request(CMD_ENQ, 16'h00a2, 16'd50, 8'd5, '0);
    send_request(CMD_ADV, '0, '0, '0, 16'd30);
    send_request(CMD_ENQ, 16'h00a3, 16'd10, 8'd200, '0);
    send_request(CMD_ADV, '0, '0, '0, 16'hffff);
    send_request(CMD_ADV, '0, '0, '0, 16'hffff);
    send_request(CMD_ADV, '0, '0, '0, 16'hfffe);
    set_capacity(5'd2);
    send_request(CMD_ENQ, 16'h0b01, 16'd20, 8'd3, '0);
    send_request(CMD_ENQ, 16'h0b02, 16'd20, 8'd3, '0);
    send_request(CMD_ENQ, 16'h0b03, 16'd20, 8'd3, '0);
    send_request(CMD_ADV, '0, '0, '0, 16'hffff);
    set_capacity(5'd0);
    send_request(CMD_ENQ, 16'h0c01, 16'd5, 8'd1, '0);
    send_request(CMD_ADV, '0, '0, '0, 16'd9);

    // random phases across capacity settings
    set_capacity(5'd16);
    repeat (80) random_request();
    set_capacity(5'd1);
    repeat (30) random_request();
    set_capacity(5'd31);
    repeat (80) random_request();
    set_capacity(5'd0);
    repeat (10) random_request();
    set_capacity(5'd4);
    repeat (50) random_request();
    set_capacity(5'd16);
    quiet <= 1'b1;
    repeat (130) random_request();
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
